### design/tns_pkg.sv
// ----------------------------------------------------------------------------
// tns_pkg
// Shared types and constants of the nearest-neighbour texture sampler.
// ----------------------------------------------------------------------------
package tns_pkg;

   // Widths fixed by the item fields and configuration registers.
   localparam int unsigned COORD_W = 32;
   localparam int unsigned EXT_W   = 13;
   localparam int unsigned TEXEL_W = 32;
   localparam int unsigned WIDX_W  = 16;
   localparam int unsigned CSR_W   = 1;
   // A texel address row * width + column fits in 2 * EXT_W + 1 bits.
   localparam int unsigned IDX_W   = 2 * EXT_W + 1;
   // Normalized coordinate after repeat or clamp: 0 .. 1.0 in Q1.16.
   localparam int unsigned QN_W    = 17;
   localparam int unsigned PROD_W  = QN_W + EXT_W;

   // Request actions.
   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_FETCH  = 2'd1,
      ACT_SAMPLE = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   // Configuration register indexes.
   typedef enum logic [CSR_W-1:0] {
      REG_TEX_WIDTH  = 1'd0,
      REG_TEX_HEIGHT = 1'd1
   } csr_index_type;

   // Operation of a coordinate unit.
   typedef enum logic [1:0] {
      OP_CLAMP  = 2'd0,
      OP_REPEAT = 2'd1,
      OP_SAMPLE = 2'd2
   } crd_op_type;

   // Coordinate unit states.
   typedef enum logic [1:0] {
      CRD_IDLE   = 2'd0,
      CRD_DIV    = 2'd1,
      CRD_FINISH = 2'd2
   } crd_state_type;

   // Sampler sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_COORD = 3'd1,
      ST_MUL   = 3'd2,
      ST_ADD   = 3'd3,
      ST_READ  = 3'd4
   } smp_state_type;

   // Command to a coordinate unit. For a sample, wrap selects the fraction
   // (repeat) rather than the clamp to 0 .. 1.0.
   typedef struct packed {
      logic                      start;
      crd_op_type                op;
      logic                      wrap;
      logic signed [COORD_W-1:0] coord;
   } crd_cmd_type;

   // Status back from a coordinate unit.
   typedef struct packed {
      logic             done;
      logic [EXT_W-1:0] value;
   } crd_sts_type;

endpackage

### design/tns_ram.sv
// ----------------------------------------------------------------------------
// tns_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module tns_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 65536
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tns_coord.sv
// ----------------------------------------------------------------------------
// tns_coord
// Maps one coordinate onto a texel column or row: clamp to edge, true
// non-negative modulo of the extent (bit-serial remainder), or scaling of a
// Q16.16 normalized coordinate by the extent.
// ----------------------------------------------------------------------------
module tns_coord (
   input  logic                       clock,
   input  logic                       reset,
   input  tns_pkg::crd_cmd_type       cmd,
   input  logic [tns_pkg::EXT_W-1:0]  extent,
   output tns_pkg::crd_sts_type       sts
);
   import tns_pkg::*;

   crd_state_type        state_ff, state_in;
   crd_op_type           op_ff, op_in;
   logic [COORD_W-1:0]   mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [EXT_W-1:0]     rem_ff, rem_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [EXT_W-1:0]     value_ff, value_in;
   logic                 done_ff, done_in;

   logic [EXT_W:0]       shifted;
   logic [EXT_W:0]       ext_wide;
   logic [QN_W-1:0]      qn;
   logic [EXT_W-1:0]     clamped;
   logic [EXT_W:0]       scaled;

   assign ext_wide = {1'b0, extent};
   assign shifted  = {rem_ff, mag_ff[COORD_W-1]};
   assign scaled   = prod_ff[PROD_W-1:16];

   // Clamp of an integer coordinate to 0 .. extent-1.
   always_comb begin
      if (cmd.coord[COORD_W-1]) begin
         clamped = '0;
      end else if ((cmd.coord[COORD_W-2:EXT_W] != '0) || (cmd.coord[EXT_W-1:0] >= extent)) begin
         clamped = extent - EXT_W'(1);
      end else begin
         clamped = cmd.coord[EXT_W-1:0];
      end
   end

   // Normalized coordinate after repeat (fraction) or clamp to 0 .. 1.0.
   always_comb begin
      if (cmd.wrap) begin
         qn = {1'b0, cmd.coord[15:0]};
      end else if (cmd.coord[COORD_W-1]) begin
         qn = '0;
      end else if ((cmd.coord[COORD_W-2:QN_W] != '0) || (cmd.coord[QN_W-1:0] > 17'h10000)) begin
         qn = 17'h10000;
      end else begin
         qn = cmd.coord[QN_W-1:0];
      end
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CRD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      value_ff <= value_in;
   end

   // Next state and datapath control.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      value_in = value_ff;
      done_in  = 1'b0;
      case (state_ff)
         CRD_IDLE: begin
            if (cmd.start) begin
               op_in = cmd.op;
               case (cmd.op)
                  OP_REPEAT: begin
                     // Divide the magnitude; the sign is put back at the end.
                     neg_in   = cmd.coord[COORD_W-1];
                     mag_in   = cmd.coord[COORD_W-1] ? COORD_W'(-cmd.coord)
                                                     : COORD_W'(cmd.coord);
                     rem_in   = '0;
                     cnt_in   = '1;
                     state_in = CRD_DIV;
                  end
                  OP_SAMPLE: begin
                     prod_in  = PROD_W'(qn) * PROD_W'(extent);
                     state_in = CRD_FINISH;
                  end
                  default: begin
                     rem_in   = clamped;
                     state_in = CRD_FINISH;
                  end
               endcase
            end
         end
         CRD_DIV: begin
            // One restoring remainder step per cycle, most significant bit first.
            if (shifted >= ext_wide) begin
               rem_in = EXT_W'(shifted - ext_wide);
            end else begin
               rem_in = shifted[EXT_W-1:0];
            end
            mag_in = {mag_ff[COORD_W-2:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               state_in = CRD_FINISH;
            end
         end
         CRD_FINISH: begin
            case (op_ff)
               OP_REPEAT: begin
                  value_in = (neg_ff && (rem_ff != '0)) ? (extent - rem_ff) : rem_ff;
               end
               OP_SAMPLE: begin
                  value_in = (scaled >= ext_wide) ? (extent - EXT_W'(1))
                                                  : scaled[EXT_W-1:0];
               end
               default: begin
                  value_in = rem_ff;
               end
            endcase
            done_in  = 1'b1;
            state_in = CRD_IDLE;
         end
         default: begin
            state_in = CRD_IDLE;
         end
      endcase
   end

   assign sts.done  = done_ff;
   assign sts.value = value_ff;

endmodule

### design/texture_nearest_sampler.sv
// ----------------------------------------------------------------------------
// texture_nearest_sampler
// Nearest-neighbour RGBA texture sampler with repeat or clamp-to-edge
// addressing over a texel RAM that is loaded by write words.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Carries
//   req_     in         req_valid/req_stall  write, integer fetch or sample
//   rsp_     out        rsp_valid/rsp_stall  RGBA colour and index overflow
//   csr_     in         csr_valid/csr_ready  tex_width / tex_height writes
//
// A write enters the texel RAM when accepted. A fetch or a finite sample passes
// the coordinate units, then the multiply, add and read stages; a repeat fetch
// adds the 32-step bit-serial remainder. An empty texture goes straight to the
// read stage. The next request is taken in the cycle after the result word is loaded.
// Reset clears the sequencer and the extents; the texel RAM is not cleared.
// A waiting result word sits in the output register while the next request
// is taken; a result is only held back in the read stage if that register is
// still full and stalled.
// ----------------------------------------------------------------------------
module texture_nearest_sampler #(
   parameter int unsigned MAX_TEXELS = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_action,
   input  logic                          req_wrap_repeat,
   input  logic signed [31:0]            req_coord_x,
   input  logic signed [31:0]            req_coord_y,
   input  logic signed [31:0]            req_coord_u,
   input  logic signed [31:0]            req_coord_v,
   input  logic                          req_coord_not_finite,
   input  logic [tns_pkg::WIDX_W-1:0]    req_write_index,
   input  logic [tns_pkg::TEXEL_W-1:0]   req_write_texel,
   // Result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_red,
   output logic [7:0]                    rsp_green,
   output logic [7:0]                    rsp_blue,
   output logic [7:0]                    rsp_alpha,
   output logic                          rsp_index_overflow,
   // Configuration channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tns_pkg::CSR_W-1:0]     csr_index,
   input  logic [tns_pkg::EXT_W-1:0]     csr_data
);
   import tns_pkg::*;

   localparam int unsigned AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;
   localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_TEXELS);

   smp_state_type          state_ff, state_in;
   logic [EXT_W-1:0]       tex_width_ff, tex_height_ff;
   logic [EXT_W-1:0]       col_ff, col_in, row_ff, row_in;
   logic [2*EXT_W-1:0]     prod_ff;
   logic                   zero_ff, zero_in;
   logic                   ovf_ff, ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             red_ff, green_ff, blue_ff, alpha_ff;
   logic                   rsp_ovf_ff;

   logic                   req_accept;
   logic                   load_out;
   logic                   empty;
   logic                   rd_en;
   logic [IDX_W-1:0]       idx;
   logic [IDX_W-1:0]       widx_ext;
   logic                   wr_en;
   logic [TEXEL_W-1:0]     rd_data;
   crd_cmd_type            cmd_x, cmd_y;
   crd_sts_type            sts_x, sts_y;
   crd_op_type             op_sel;

   assign req_accept = req_valid && !req_stall;
   assign empty      = (tex_width_ff == '0) || (tex_height_ff == '0);
   assign idx        = IDX_W'(prod_ff) + IDX_W'(col_ff);
   assign widx_ext   = IDX_W'(req_write_index);

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= '0;
         tex_height_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            REG_TEX_WIDTH:  tex_width_ff  <= csr_data;
            REG_TEX_HEIGHT: tex_height_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Coordinate unit commands: both units run the same operation together.
   always_comb begin
      if (action_type'(req_action) == ACT_SAMPLE) begin
         op_sel = OP_SAMPLE;
      end else if (req_wrap_repeat) begin
         op_sel = OP_REPEAT;
      end else begin
         op_sel = OP_CLAMP;
      end
   end

   assign cmd_x.start = (state_ff == ST_IDLE) && req_accept && !empty &&
                        ((action_type'(req_action) == ACT_FETCH) ||
                         ((action_type'(req_action) == ACT_SAMPLE) && !req_coord_not_finite));
   assign cmd_x.op    = op_sel;
   assign cmd_x.wrap  = req_wrap_repeat;
   assign cmd_x.coord = (action_type'(req_action) == ACT_SAMPLE) ? req_coord_u : req_coord_x;
   assign cmd_y.start = cmd_x.start;
   assign cmd_y.op    = op_sel;
   assign cmd_y.wrap  = req_wrap_repeat;
   assign cmd_y.coord = (action_type'(req_action) == ACT_SAMPLE) ? req_coord_v : req_coord_y;

   tns_coord u_coord_x (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd_x),
      .extent (tex_width_ff),
      .sts    (sts_x)
   );

   tns_coord u_coord_y (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd_y),
      .extent (tex_height_ff),
      .sts    (sts_y)
   );

   // Texel RAM: writes straight from the request, reads from the address stage.
   assign wr_en = req_accept && (action_type'(req_action) == ACT_WRITE) &&
                  (widx_ext < MAX_IDX);

   tns_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (MAX_TEXELS)
   ) u_texel_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (widx_ext[AW-1:0]),
      .wr_data (req_write_texel),
      .rd_en   (rd_en),
      .rd_addr (idx[AW-1:0]),
      .rd_data (rd_data)
   );

   // Sequencer state and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Address datapath and output word registers.
   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      row_ff  <= row_in;
      zero_ff <= zero_in;
      ovf_ff  <= ovf_in;
      prod_ff <= row_ff * tex_width_ff;
      if (load_out) begin
         red_ff     <= zero_ff ? 8'd0 : rd_data[7:0];
         green_ff   <= zero_ff ? 8'd0 : rd_data[15:8];
         blue_ff    <= zero_ff ? 8'd0 : rd_data[23:16];
         alpha_ff   <= zero_ff ? 8'd0 : rd_data[31:24];
         rsp_ovf_ff <= ovf_ff;
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      zero_in      = zero_ff;
      ovf_in       = ovf_ff;
      rd_en        = 1'b0;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && ((action_type'(req_action) == ACT_FETCH) ||
                               (action_type'(req_action) == ACT_SAMPLE))) begin
               if (empty) begin
                  // No texture: zero colour without a lookup.
                  zero_in  = 1'b1;
                  ovf_in   = 1'b0;
                  state_in = ST_READ;
               end else if (cmd_x.start) begin
                  state_in = ST_COORD;
               end else begin
                  // Not-finite sample reads the texel at the origin.
                  col_in   = '0;
                  row_in   = '0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_COORD: begin
            if (sts_x.done) begin
               col_in   = sts_x.value;
               row_in   = sts_y.value;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            // Address check and RAM read.
            ovf_in   = (idx >= MAX_IDX);
            zero_in  = (idx >= MAX_IDX);
            rd_en    = (idx < MAX_IDX);
            state_in = ST_READ;
         end
         ST_READ: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_red            = red_ff;
   assign rsp_green          = green_ff;
   assign rsp_blue           = blue_ff;
   assign rsp_alpha          = alpha_ff;
   assign rsp_index_overflow = rsp_ovf_ff;

   // The two coordinate units always finish in the same cycle.
   assert property (@(posedge clock) disable iff (reset) sts_x.done == sts_y.done)
      else $error("coordinate units out of step");

   // A coordinate result only arrives while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset) sts_x.done |-> state_ff == ST_COORD)
      else $error("coordinate result outside the coordinate stage");

   // An overflowing address always gives a zero colour.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && ovf_ff) |-> zero_ff)
      else $error("overflow without zero colour");

   // An accepted lookup leaves the idle state in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && ((action_type'(req_action) == ACT_FETCH) ||
                      (action_type'(req_action) == ACT_SAMPLE))) |=> state_ff != ST_IDLE)
      else $error("lookup accepted but sequencer stayed idle");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest-neighbour texture sampler. A generator
// fills a backlog of request words, phase by phase, under a series of texture
// extents. Every texel that a lookup will read is loaded by a write word
// first. A clocked driver offers the words with random gaps. A clocked
// monitor stalls at random and checks each result word against the colour
// predicted when its request was accepted.
// ----------------------------------------------------------------------------
module tb;
   import tns_pkg::*;

   localparam int unsigned MAX_TEXELS = 65536;
   // Longest quiet stretch of a correct run: the receiver hold-off, a repeat
   // fetch, the random gaps and the pause between phases.
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;

   typedef struct {
      action_type         action;
      logic               wrap_repeat;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_u;
      logic signed [31:0] coord_v;
      logic               coord_not_finite;
      logic [15:0]        write_index;
      logic [31:0]        write_texel;
   } sampler_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       overflow;
   } colour_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_action;
   logic                 req_wrap_repeat;
   logic signed [31:0]   req_coord_x;
   logic signed [31:0]   req_coord_y;
   logic signed [31:0]   req_coord_u;
   logic signed [31:0]   req_coord_v;
   logic                 req_coord_not_finite;
   logic [WIDX_W-1:0]    req_write_index;
   logic [TEXEL_W-1:0]   req_write_texel;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [7:0]           rsp_red;
   logic [7:0]           rsp_green;
   logic [7:0]           rsp_blue;
   logic [7:0]           rsp_alpha;
   logic                 rsp_index_overflow;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_W-1:0]     csr_index;
   logic [EXT_W-1:0]     csr_data;

   // Mirror of the block's state, kept up to date on accepted words.
   int unsigned  tex_width_model;
   int unsigned  tex_height_model;
   logic [31:0]  texel_mirror [MAX_TEXELS];
   // Texels that the generator has already scheduled a write for.
   bit           texel_written [MAX_TEXELS];

   sampler_req_type req_backlog [$];
   colour_type      colour_due [$];
   sampler_req_type req_now;

   int unsigned items_queued;
   int unsigned items_accepted;
   int unsigned writes_done;
   int unsigned lookups_checked;
   int unsigned overflows_seen;
   int unsigned extent_writes;
   int unsigned mismatches;
   int unsigned idle_cycles;
   int unsigned req_gap_left;
   int unsigned rsp_gap_left;
   int unsigned hold_left;
   int unsigned req_gap_pct;
   int unsigned rsp_gap_pct;
   bit          quiet_run;
   bit          hold_off_pending;
   bit          hold_off_taken;

   texture_nearest_sampler #(.MAX_TEXELS(MAX_TEXELS)) dut (.*);

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   function automatic longint clamp_to(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Integer coordinate: true non-negative modulo, or clamp to the edge.
   function automatic longint wrap_texel(logic signed [31:0] c, int unsigned extent,
                                         logic rep);
      longint cv;
      longint ev;
      longint r;
      cv = c;
      ev = extent;
      if (rep) begin
         r = cv % ev;
         if (r < 0) r += ev;
         return r;
      end
      return clamp_to(cv, 0, ev - 1);
   endfunction

   // Q16.16 coordinate: fraction or clamp to 0..1.0, then scale by the extent.
   function automatic longint scale_norm(logic signed [31:0] t, int unsigned extent,
                                         logic rep);
      longint q;
      longint ev;
      ev = extent;
      if (rep) q = longint'(t[15:0]);
      else q = clamp_to(longint'(t), 0, 65536);
      q = (q * ev) >>> 16;
      return clamp_to(q, 0, ev - 1);
   endfunction

   // Texel address of a lookup; -1 when the texture is empty.
   function automatic longint texel_address(sampler_req_type r, int unsigned w,
                                            int unsigned h);
      longint col;
      longint row;
      if (w == 0 || h == 0) return -1;
      if (r.action == ACT_FETCH) begin
         col = wrap_texel(r.coord_x, w, r.wrap_repeat);
         row = wrap_texel(r.coord_y, h, r.wrap_repeat);
      end else if (r.coord_not_finite) begin
         col = 0;
         row = 0;
      end else begin
         col = scale_norm(r.coord_u, w, r.wrap_repeat);
         row = scale_norm(r.coord_v, h, r.wrap_repeat);
      end
      return row * longint'(w) + col;
   endfunction

   function automatic colour_type predict_colour(sampler_req_type r);
      longint      addr;
      logic [31:0] t;
      colour_type  c;
      addr = texel_address(r, tex_width_model, tex_height_model);
      c = '0;
      if (addr >= longint'(MAX_TEXELS)) begin
         c.overflow = 1'b1;
      end else if (addr >= 0) begin
         t = texel_mirror[addr];
         c.red   = t[7:0];
         c.green = t[15:8];
         c.blue  = t[23:16];
         c.alpha = t[31:24];
      end
      return c;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------------

   function automatic sampler_req_type lookup_req(action_type a, logic rep,
                                                  logic signed [31:0] x,
                                                  logic signed [31:0] y,
                                                  logic signed [31:0] u,
                                                  logic signed [31:0] v,
                                                  logic nf);
      sampler_req_type r;
      r.action           = a;
      r.wrap_repeat      = rep;
      r.coord_x          = x;
      r.coord_y          = y;
      r.coord_u          = u;
      r.coord_v          = v;
      r.coord_not_finite = nf;
      r.write_index      = 16'($urandom);
      r.write_texel      = $urandom;
      return r;
   endfunction

   function automatic sampler_req_type write_req(logic [15:0] idx, logic [31:0] texel);
      sampler_req_type r;
      r = lookup_req(ACT_WRITE, 1'($urandom), $urandom, $urandom, $urandom, $urandom,
                     1'($urandom));
      r.write_index = idx;
      r.write_texel = texel;
      return r;
   endfunction

   function automatic logic signed [31:0] pick_int(int unsigned extent);
      int signed span;
      span = extent;
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return (extent == 0) ? 0 : $urandom_range(0, extent - 1);
         2: return int'($urandom_range(0, 4 * extent + 8)) - 2 * span - 4;
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return -1;
               3: return span;
               default: return -span;
            endcase
         end
      endcase
   endfunction

   function automatic logic signed [31:0] pick_norm();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return int'($urandom_range(0, 32'h40000)) - 32'sh20000;
         2: return $urandom_range(0, 32'h10000);
         default: begin
            case ($urandom_range(0, 6))
               0: return 0;
               1: return 32'sh1_0000;
               2: return 32'sh0_FFFF;
               3: return -1;
               4: return 32'sh8000_0000;
               5: return 32'sh7FFF_FFFF;
               default: return 32'sh0_8000;
            endcase
         end
      endcase
   endfunction

   function automatic sampler_req_type random_req();
      sampler_req_type r;
      int unsigned     p;
      int unsigned     used;
      p = $urandom_range(0, 99);
      r = lookup_req(ACT_SAMPLE, 1'($urandom), pick_int(tex_width_model),
                     pick_int(tex_height_model), pick_norm(), pick_norm(),
                     $urandom_range(0, 9) == 0);
      if (p < 18) r.action = ACT_WRITE;
      else if (p < 53) r.action = ACT_FETCH;
      else if (p < 95) r.action = ACT_SAMPLE;
      else r.action = ACT_NONE;
      // Half of the writes land in the part of the store that the texture covers.
      used = tex_width_model * tex_height_model;
      if (used > MAX_TEXELS) used = MAX_TEXELS;
      if (used > 0 && $urandom_range(0, 1))
         r.write_index = 16'($urandom_range(0, used - 1));
      return r;
   endfunction

   // Queue a word; a lookup of a texel not yet loaded gets a write first.
   task automatic queue_req(sampler_req_type r);
      longint addr;
      if (r.action == ACT_FETCH || r.action == ACT_SAMPLE) begin
         addr = texel_address(r, tex_width_model, tex_height_model);
         if (addr >= 0 && addr < longint'(MAX_TEXELS) && !texel_written[addr]) begin
            texel_written[addr] = 1'b1;
            req_backlog.push_back(write_req(addr[15:0], $urandom));
            items_queued++;
         end
      end
      if (r.action == ACT_WRITE) texel_written[r.write_index] = 1'b1;
      req_backlog.push_back(r);
      items_queued++;
   endtask

   task automatic write_extent(csr_index_type which, int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= value[EXT_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (which == REG_TEX_WIDTH) tex_width_model = value;
      else tex_height_model = value;
      extent_writes++;
   endtask

   task automatic set_extents(int unsigned w, int unsigned h);
      write_extent(REG_TEX_WIDTH, w);
      write_extent(REG_TEX_HEIGHT, h);
   endtask

   // Wait until every word is accepted and every result has come, then let
   // a write or an ignored word still in the pipeline finish.
   task automatic drain();
      @(negedge clock);
      while (items_accepted != items_queued || colour_due.size() != 0) @(negedge clock);
      repeat (50) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      bit offer;
      if (reset) begin
         req_valid            <= 1'b0;
         req_action           <= ACT_NONE;
         req_wrap_repeat      <= 1'b0;
         req_coord_x          <= '0;
         req_coord_y          <= '0;
         req_coord_u          <= '0;
         req_coord_v          <= '0;
         req_coord_not_finite <= 1'b0;
         req_write_index      <= '0;
         req_write_texel      <= '0;
         req_gap_left = 0;
      end else begin
         // Predict on acceptance so the mirror follows the block's order.
         if (req_valid && !req_stall) begin
            if (req_now.action == ACT_WRITE) begin
               texel_mirror[req_now.write_index] = req_now.write_texel;
               writes_done++;
            end else if (req_now.action != ACT_NONE) begin
               colour_due.push_back(predict_colour(req_now));
            end
            items_accepted++;
         end
         // A stalled word is held; otherwise offer the next one or idle.
         if (!req_valid || !req_stall) begin
            offer = 1'b0;
            if (req_gap_left > 0) begin
               req_gap_left--;
            end else if (req_backlog.size() > 0) begin
               if (!quiet_run && $urandom_range(0, 99) < req_gap_pct) begin
                  req_gap_left = $urandom_range(0, 15);
               end else begin
                  req_now = req_backlog.pop_front();
                  offer = 1'b1;
               end
            end
            req_valid <= offer;
            if (offer) begin
               req_action           <= req_now.action;
               req_wrap_repeat      <= req_now.wrap_repeat;
               req_coord_x          <= req_now.coord_x;
               req_coord_y          <= req_now.coord_y;
               req_coord_u          <= req_now.coord_u;
               req_coord_v          <= req_now.coord_v;
               req_coord_not_finite <= req_now.coord_not_finite;
               req_write_index      <= req_now.write_index;
               req_write_texel      <= req_now.write_texel;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor
   // ------------------------------------------------------------------------
   task automatic note_mismatch(string what, colour_type want, colour_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected r=%h g=%h b=%h a=%h ovf=%b, got r=%h g=%h b=%h a=%h ovf=%b",
                  $realtime, what, want.red, want.green, want.blue, want.alpha,
                  want.overflow, got.red, got.green, got.blue, got.alpha, got.overflow);
   endtask

   always @(posedge clock) begin : rsp_monitor
      colour_type got;
      colour_type want;
      bit         hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap_left = 0;
         hold_left = 0;
         hold_off_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.red      = rsp_red;
            got.green    = rsp_green;
            got.blue     = rsp_blue;
            got.alpha    = rsp_alpha;
            got.overflow = rsp_index_overflow;
            if (got.overflow === 1'b1) overflows_seen++;
            if (colour_due.size() == 0) begin
               note_mismatch("result word with nothing expected", '0, got);
            end else begin
               want = colour_due.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.alpha !== want.alpha ||
                   got.overflow !== want.overflow)
                  note_mismatch("result word differs", want, got);
            end
            lookups_checked++;
         end
         // The long hold-off is counted here; otherwise random stall bursts from rsp_gap_pct.
         if (hold_off_pending && !hold_off_taken) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_taken = 1'b1;
         end
         hold = 1'b1;
         if (hold_left > 0) hold_left--;
         else if (rsp_gap_left > 0) rsp_gap_left--;
         else if (!quiet_run && $urandom_range(0, 99) < rsp_gap_pct)
            rsp_gap_left = $urandom_range(0, 15);
         else hold = 1'b0;
         rsp_stall <= hold;
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: cycles in a row with no word moving on any channel.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles.", idle_cycles);
         $display("** texture_nearest_sampler: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : sequence_run
      int unsigned w;
      int unsigned h;
      csr_valid            = 1'b0;
      csr_index            = REG_TEX_WIDTH;
      csr_data             = '0;
      req_gap_pct          = 10;
      rsp_gap_pct          = 10;
      quiet_run            = 1'b0;
      hold_off_pending     = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty texture: lookups give zero colour; ignored and extreme writes.
      set_extents(0, 0);
      queue_req(lookup_req(ACT_FETCH, 1'b1, 5, -3, 0, 0, 1'b0));
      queue_req(lookup_req(ACT_SAMPLE, 1'b0, 0, 0, 32'sh8000, 32'sh8000, 1'b0));
      queue_req(lookup_req(ACT_SAMPLE, 1'b1, 0, 0, 0, 0, 1'b1));
      queue_req(lookup_req(ACT_NONE, 1'b0, 0, 0, 0, 0, 1'b0));
      queue_req(write_req(16'h0000, 32'h0403_0201));
      queue_req(write_req(16'hFFFF, 32'hFFFF_FFFF));
      drain();

      // Width set but height zero is still an empty texture.
      set_extents(37, 0);
      queue_req(lookup_req(ACT_FETCH, 1'b0, 1, 1, 0, 0, 1'b0));
      queue_req(lookup_req(ACT_SAMPLE, 1'b1, 0, 0, 32'sh4000, 32'sh4000, 1'b0));
      drain();

      // Single-texel texture with extreme coordinates.
      set_extents(1, 1);
      queue_req(lookup_req(ACT_FETCH, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 1'b0));
      queue_req(lookup_req(ACT_FETCH, 1'b0, -1, 32'sh7FFF_FFFF, 0, 0, 1'b0));
      queue_req(lookup_req(ACT_SAMPLE, 1'b1, 0, 0, -1, 32'sh8000, 1'b0));
      queue_req(lookup_req(ACT_SAMPLE, 1'b0, 0, 0, 32'sh1_0000, 32'sh7FFF_FFFF, 1'b0));
      queue_req(lookup_req(ACT_SAMPLE, 1'b0, 0, 0, 32'sh8000_0000, 5, 1'b1));
      drain();

      // A 4096 by 4096 texture: addresses past the store overflow.
      set_extents(4096, 4096);
      queue_req(lookup_req(ACT_FETCH, 1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 1'b0));
      queue_req(lookup_req(ACT_FETCH, 1'b1, -1, 15, 0, 0, 1'b0));
      queue_req(lookup_req(ACT_FETCH, 1'b1, 0, 16, 0, 0, 1'b0));
      queue_req(lookup_req(ACT_SAMPLE, 1'b0, 0, 0, 32'sh1_0000, 0, 1'b0));
      queue_req(lookup_req(ACT_SAMPLE, 1'b1, 0, 0, 32'sh0_FFFF, 32'sh0_FFFF, 1'b0));
      queue_req(lookup_req(ACT_SAMPLE, 1'b1, 0, 0, -7, 32'sh7FFF_FFFF, 1'b1));
      queue_req(lookup_req(ACT_NONE, 1'b1, 0, 0, 0, 0, 1'b1));
      drain();

      // Random phases, each under fresh extents; mostly small textures.
      for (int ph = 0; ph < 12; ph++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               w = $urandom_range(1, 16);
               h = $urandom_range(1, 16);
            end
            6, 7: begin
               w = $urandom_range(17, 300);
               h = $urandom_range(1, 300);
            end
            8: begin
               w = $urandom_range(0, 1) ? 4096 : $urandom_range(1, 16);
               h = (w == 4096) ? $urandom_range(1, 16) : 4096;
            end
            default: begin
               w = $urandom_range(0, 1) ? 0 : 4096;
               h = (w == 0) ? $urandom_range(1, 4096) : 4096;
            end
         endcase
         set_extents(w, h);
         req_gap_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 10 : 30;
         rsp_gap_pct = req_gap_pct;
         if (ph == 1) begin
            // Receiver holds off while the sender keeps offering words.
            req_gap_pct = 0;
            hold_off_pending = 1'b1;
         end
         if (ph == 11) quiet_run = 1'b1;
         for (int n = 0; n < 50; n++) queue_req(random_req());
         drain();
      end

      $display("Run covered %0d request words (%0d texel writes) and %0d lookups checked,",
               items_accepted, writes_done, lookups_checked);
      $display("with %0d overflowed lookups over %0d extent register writes; %0d mismatches.",
               overflows_seen, extent_writes, mismatches);
      if (mismatches == 0 && colour_due.size() == 0) begin
         $display("** texture_nearest_sampler: PASSED **");
      end else begin
         $display("** texture_nearest_sampler: FAILED **");
      end
      $finish;
   end

endmodule

### texture_nearest_sampler.f
design/tns_pkg.sv
design/tns_ram.sv
design/tns_coord.sv
design/texture_nearest_sampler.sv
test/tb.sv
